// ===== rtl/ptcp_pkg.sv =====
// Package for the point-to-triangle closest point block.
// Holds widths, weight constants, the request, result and job types and the dot product.
// Depends on nothing.
`default_nettype none
package ptcp_pkg;
   localparam int COORD_BITS = 24;
   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int DOT_BITS = 2 * DIFF_BITS + 1;
   localparam int GRAD_BITS = DOT_BITS + 20;
   localparam int DIV_BITS = GRAD_BITS + 2;
   localparam int WEIGHT_BITS = 17;
   localparam int SQD_BITS = 52;
   localparam int DIST_BITS = 26;
   localparam int FRAC_STEPS = 17;
   localparam int SQRT_STEPS = SQD_BITS / 2;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam logic [WEIGHT_BITS-1:0] ONE_Q16 = 17'h10000;
   localparam logic [WEIGHT_BITS-1:0] HALF_Q16 = 17'h08000;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] query_x;
      logic signed [COORD_BITS-1:0] query_y;
      logic signed [COORD_BITS-1:0] query_z;
      logic signed [COORD_BITS-1:0] vertex0_x;
      logic signed [COORD_BITS-1:0] vertex0_y;
      logic signed [COORD_BITS-1:0] vertex0_z;
      logic signed [COORD_BITS-1:0] vertex1_x;
      logic signed [COORD_BITS-1:0] vertex1_y;
      logic signed [COORD_BITS-1:0] vertex1_z;
      logic signed [COORD_BITS-1:0] vertex2_x;
      logic signed [COORD_BITS-1:0] vertex2_y;
      logic signed [COORD_BITS-1:0] vertex2_z;
   } req_type;

   typedef struct packed {
      logic [WEIGHT_BITS-1:0] weight0;
      logic [WEIGHT_BITS-1:0] weight1;
      logic [WEIGHT_BITS-1:0] weight2;
      logic signed [COORD_BITS-1:0] closest_x;
      logic signed [COORD_BITS-1:0] closest_y;
      logic signed [COORD_BITS-1:0] closest_z;
      logic [SQD_BITS-1:0] squared_distance;
      logic [DIST_BITS-1:0] distance;
   } rsp_type;

   typedef struct packed {
      logic [2:0][COORD_BITS-1:0] pt;
      logic [2:0][COORD_BITS-1:0] v0;
      logic [2:0][DIFF_BITS-1:0] eu;
      logic [2:0][DIFF_BITS-1:0] ev;
      logic [DOT_BITS-1:0] uu;
      logic [DOT_BITS-1:0] uv;
      logic [DOT_BITS-1:0] vv;
      logic [DOT_BITS-1:0] lu;
      logic [DOT_BITS-1:0] lv;
   } job_type;

   function automatic logic signed [DOT_BITS-1:0] dot3(input logic [2:0][DIFF_BITS-1:0] a,
                                                       input logic [2:0][DIFF_BITS-1:0] b);
      logic signed [DOT_BITS-1:0] acc;
      acc = '0;
      for (int i = 0; i < 3; i++) begin
         acc = acc + DOT_BITS'($signed(a[i]) * $signed(b[i]));
      end
      return acc;
   endfunction
endpackage
`default_nettype wire

// ===== rtl/ptcp_front.sv =====
// Front end: accepts requests, forms edge vectors and exact dot products in two stages.
// Depends on ptcp_pkg; feeds ptcp_queue and holds off requests on queue credit.
`default_nettype none
module ptcp_front #(
   parameter int QUEUE_DEPTH = ptcp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire ptcp_pkg::req_type                req_data,
   input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count,
   output logic                                  busy,
   output logic                                  push,
   output ptcp_pkg::job_type                     push_data
);
   import ptcp_pkg::*;

   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   logic [2:0][COORD_BITS-1:0] q_a, v0_a, v1_a, v2_a;
   logic [2:0][DIFF_BITS-1:0] eu_c, ev_c, dv_c;
   logic accept;
   logic [CNT_BITS+1:0] in_flight;

   logic s1_valid_ff, s2_valid_ff;
   logic [2:0][COORD_BITS-1:0] s1_pt_ff, s1_v0_ff;
   logic [2:0][DIFF_BITS-1:0] s1_eu_ff, s1_ev_ff, s1_dv_ff;
   job_type s2_job_ff;

   assign q_a  = {req_data.query_z, req_data.query_y, req_data.query_x};
   assign v0_a = {req_data.vertex0_z, req_data.vertex0_y, req_data.vertex0_x};
   assign v1_a = {req_data.vertex1_z, req_data.vertex1_y, req_data.vertex1_x};
   assign v2_a = {req_data.vertex2_z, req_data.vertex2_y, req_data.vertex2_x};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         eu_c[i] = DIFF_BITS'($signed(v1_a[i])) - DIFF_BITS'($signed(v0_a[i]));
         ev_c[i] = DIFF_BITS'($signed(v2_a[i])) - DIFF_BITS'($signed(v0_a[i]));
         dv_c[i] = DIFF_BITS'($signed(q_a[i])) - DIFF_BITS'($signed(v0_a[i]));
      end
   end

   assign in_flight = (CNT_BITS+2)'(s1_valid_ff) + (CNT_BITS+2)'(s2_valid_ff)
                      + (CNT_BITS+2)'(q_count);
   assign busy = in_flight >= (CNT_BITS+2)'(QUEUE_DEPTH);
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
      end
      s1_pt_ff <= q_a;
      s1_v0_ff <= v0_a;
      s1_eu_ff <= eu_c;
      s1_ev_ff <= ev_c;
      s1_dv_ff <= dv_c;
      s2_job_ff.pt <= s1_pt_ff;
      s2_job_ff.v0 <= s1_v0_ff;
      s2_job_ff.eu <= s1_eu_ff;
      s2_job_ff.ev <= s1_ev_ff;
      s2_job_ff.uu <= dot3(s1_eu_ff, s1_eu_ff);
      s2_job_ff.uv <= dot3(s1_eu_ff, s1_ev_ff);
      s2_job_ff.vv <= dot3(s1_ev_ff, s1_ev_ff);
      s2_job_ff.lu <= -dot3(s1_dv_ff, s1_eu_ff);
      s2_job_ff.lv <= -dot3(s1_dv_ff, s1_ev_ff);
   end

   assign push = s2_valid_ff;
   assign push_data = s2_job_ff;
endmodule
`default_nettype wire

// ===== rtl/ptcp_queue.sv =====
// Short job queue between the front and back ends.
// Depends on ptcp_pkg for the job type.
`default_nettype none
module ptcp_queue #(
   parameter int QUEUE_DEPTH = ptcp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              push,
   input  wire ptcp_pkg::job_type                 push_data,
   input  wire logic                              pop,
   output ptcp_pkg::job_type                      pop_data,
   output logic                                   empty,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]       count
);
   import ptcp_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   job_type mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_BITS-1:0] count_ff;

   function automatic logic [PTR_BITS-1:0] wrap_inc(input logic [PTR_BITS-1:0] p);
      return (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wrap_inc(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= wrap_inc(rd_ptr_ff);
         end
         count_ff <= count_ff + CNT_BITS'(push) - CNT_BITS'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign count = count_ff;
endmodule
`default_nettype wire

// ===== rtl/ptcp_frac.sv =====
// Ratio unit: n/d clamped to [0, 1] and rounded to Q1.16, one quotient bit a cycle.
// Depends on ptcp_pkg; shared by every ratio of the back end.
`default_nettype none
module ptcp_frac (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   input  wire logic signed [ptcp_pkg::DIV_BITS-1:0]   num,
   input  wire logic signed [ptcp_pkg::DIV_BITS-1:0]   den,
   output logic                                        done,
   output logic [ptcp_pkg::WEIGHT_BITS-1:0]            quot
);
   import ptcp_pkg::*;

   localparam int UW = DIV_BITS + 1;

   logic signed [DIV_BITS-1:0] nn, dd;
   logic [UW-1:0] n2, n_next;
   logic [WEIGHT_BITS-1:0] q_next;
   logic [WEIGHT_BITS:0] q_round;

   logic run_ff, done_ff;
   logic [UW-1:0] n_ff, d_ff;
   logic [WEIGHT_BITS-1:0] q_ff, quot_ff;
   logic [4:0] cnt_ff;

   always_comb begin
      nn = den[DIV_BITS-1] ? -num : num;
      dd = den[DIV_BITS-1] ? -den : den;
      n2 = {n_ff[UW-2:0], 1'b0};
      if (n2 >= d_ff) begin
         n_next = n2 - d_ff;
         q_next = {q_ff[WEIGHT_BITS-2:0], 1'b1};
      end else begin
         n_next = n2;
         q_next = {q_ff[WEIGHT_BITS-2:0], 1'b0};
      end
      q_round = {1'b0, q_next} + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            if (dd == '0 || nn <= DIV_BITS'(0)) begin
               quot_ff <= '0;
               done_ff <= 1'b1;
            end else if (nn >= dd) begin
               quot_ff <= ONE_Q16;
               done_ff <= 1'b1;
            end else begin
               n_ff <= UW'(nn);
               d_ff <= UW'(dd);
               q_ff <= '0;
               cnt_ff <= '0;
               run_ff <= 1'b1;
            end
         end else if (run_ff) begin
            n_ff <= n_next;
            q_ff <= q_next;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == 5'(FRAC_STEPS - 1)) begin
               run_ff <= 1'b0;
               done_ff <= 1'b1;
               quot_ff <= q_round[WEIGHT_BITS:1];
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;
endmodule
`default_nettype wire

// ===== rtl/ptcp_back.sv =====
// Back end: case selection, clamped ratios, blending, closest point, distance and root.
// Depends on ptcp_pkg and ptcp_frac; takes jobs from ptcp_queue.
`default_nettype none
module ptcp_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_empty,
   input  wire ptcp_pkg::job_type   pop_data,
   output logic                     pop,
   output logic                     rsp_valid,
   output ptcp_pkg::rsp_type        rsp_data
);
   import ptcp_pkg::*;

   localparam int GB = DOT_BITS + 3;
   localparam int CLM = DIFF_BITS + WEIGHT_BITS + 1;
   localparam int CLS = CLM + 1;
   localparam int SQW = SQD_BITS + 1;
   localparam int FRAC_SLOTS = 6;
   localparam logic [2:0] SEL_EV = 3'd0;
   localparam logic [2:0] SEL_EUV = 3'd1;
   localparam logic [2:0] SEL_OV = 3'd2;
   localparam logic [2:0] SEL_VU = 3'd3;
   localparam logic [2:0] SEL_OU = 3'd4;
   localparam logic [2:0] SEL_BLEND = 3'd5;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIV, ST_SEL, ST_G0S, ST_G0T, ST_G1S, ST_G1T, ST_DEC,
      ST_BLEND, ST_CL1, ST_CL2, ST_SQ1, ST_SQ2, ST_SQRT
   } state_type;

   state_type state_ff;
   job_type job_ff;
   logic [2:0] div_sel_ff;
   logic div_run_ff;
   logic [WEIGHT_BITS-1:0] f_ff [FRAC_SLOTS];
   logic [WEIGHT_BITS-1:0] p_s_ff, p_t_ff, q_s_ff, q_t_ff, a0_s_ff, a0_t_ff, a1_s_ff, a1_t_ff;
   logic [WEIGHT_BITS-1:0] s_ff, t_ff;
   logic fpos_ff, fneg_ff;
   logic signed [GRAD_BITS-1:0] g_acc_ff, g0_ff, g1_ff;
   logic signed [CLM-1:0] su_ff [3];
   logic signed [CLM-1:0] tv_ff [3];
   logic [2:0][COORD_BITS-1:0] cl_ff;
   logic signed [2*DIFF_BITS-1:0] sq_ff [3];
   logic [SQD_BITS-1:0] sqd_ff, sv_ff, res_ff, bit_ff;
   logic [4:0] scnt_ff;
   logic rsp_valid_ff;
   rsp_type rsp_data_ff;

   logic signed [GB-1:0] uu, uv, vv, lu, lv, go, gu, gv, k0, k1;
   logic signed [DIV_BITS-1:0] div_num, div_den;
   logic signed [GRAD_BITS-1:0] m0, m1, lv_sh, prod;
   logic signed [DOT_BITS-1:0] mul_a;
   logic signed [WEIGHT_BITS:0] mul_b;
   logic div_start, div_done;
   logic [WEIGHT_BITS-1:0] div_quot;
   logic go_ge, gv_ge, gv_gt, gu_le;
   logic [WEIGHT_BITS-1:0] ev_t, euv_t, omz, w3c;
   logic signed [WEIGHT_BITS+1:0] fac_a;
   logic [34:0] bs, bt;
   logic alt0_take, alt1_take;
   logic signed [CLS-1:0] cl_sum [3];
   logic signed [CLS-1:0] cl_val [3];
   logic [2:0][COORD_BITS-1:0] cl_sat;
   logic signed [DIFF_BITS-1:0] e_c [3];
   logic [SQW-1:0] sq_sum;
   logic [SQD_BITS-1:0] trial, sv_next, res_next;
   logic [WEIGHT_BITS:0] w0;

   always_comb begin
      uu = GB'($signed(job_ff.uu));
      uv = GB'($signed(job_ff.uv));
      vv = GB'($signed(job_ff.vv));
      lu = GB'($signed(job_ff.lu));
      lv = GB'($signed(job_ff.lv));
      go = lu;
      gu = lu + uu;
      gv = lu + uv;
      k0 = uv + lv - gu;
      k1 = vv + lv - gv;
      m0 = g0_ff[GRAD_BITS-1] ? -g0_ff : g0_ff;
      m1 = g1_ff[GRAD_BITS-1] ? -g1_ff : g1_ff;
      case (div_sel_ff)
         SEL_EV: begin
            div_num = -DIV_BITS'(lv);
            div_den = DIV_BITS'(vv);
         end
         SEL_EUV: begin
            div_num = DIV_BITS'(k0);
            div_den = DIV_BITS'(k0) - DIV_BITS'(k1);
         end
         SEL_OV: begin
            div_num = DIV_BITS'(go);
            div_den = DIV_BITS'(go) - DIV_BITS'(gv);
         end
         SEL_VU: begin
            div_num = DIV_BITS'(gv);
            div_den = DIV_BITS'(gv) - DIV_BITS'(gu);
         end
         SEL_OU: begin
            div_num = DIV_BITS'(go);
            div_den = DIV_BITS'(go) - DIV_BITS'(gu);
         end
         SEL_BLEND: begin
            div_num = DIV_BITS'(m0);
            div_den = DIV_BITS'(m0) + DIV_BITS'(m1);
         end
         default: begin
            div_num = '0;
            div_den = '0;
         end
      endcase
      div_start = (state_ff == ST_DIV) && !div_run_ff;

      go_ge = !go[GB-1];
      gv_ge = !gv[GB-1];
      gv_gt = gv_ge && (gv != '0);
      gu_le = gu[GB-1] || (gu == '0);
      if (!lv[GB-1]) begin
         ev_t = '0;
      end else if ((vv + lv) <= GB'(0)) begin
         ev_t = ONE_Q16;
      end else begin
         ev_t = f_ff[SEL_EV];
      end
      if (!k0[GB-1]) begin
         euv_t = '0;
      end else if (k1 <= GB'(0)) begin
         euv_t = ONE_Q16;
      end else begin
         euv_t = f_ff[SEL_EUV];
      end
      w3c = ONE_Q16 - f_ff[SEL_VU];
      fac_a = $signed({2'b00, w3c}) - $signed({2'b00, f_ff[SEL_OV]});

      case (state_ff)
         ST_G0S: begin
            mul_a = job_ff.uv;
            mul_b = {1'b0, p_s_ff};
         end
         ST_G0T: begin
            mul_a = job_ff.vv;
            mul_b = {1'b0, p_t_ff};
         end
         ST_G1S: begin
            mul_a = job_ff.uv;
            mul_b = {1'b0, q_s_ff};
         end
         default: begin
            mul_a = job_ff.vv;
            mul_b = {1'b0, q_t_ff};
         end
      endcase
      prod = GRAD_BITS'(mul_a * mul_b);
      lv_sh = GRAD_BITS'(lv) <<< 16;

      alt0_take = !(fpos_ff || fneg_ff) || (g0_ff == '0)
                  || (fpos_ff && !g0_ff[GRAD_BITS-1]) || (fneg_ff && g0_ff[GRAD_BITS-1]);
      alt1_take = !(fpos_ff || fneg_ff) || (g1_ff == '0)
                  || (fpos_ff && g1_ff[GRAD_BITS-1]) || (fneg_ff && !g1_ff[GRAD_BITS-1]);

      omz = ONE_Q16 - f_ff[SEL_BLEND];
      bs = 35'(omz) * 35'(p_s_ff) + 35'(f_ff[SEL_BLEND]) * 35'(q_s_ff) + 35'(HALF_Q16);
      bt = 35'(omz) * 35'(p_t_ff) + 35'(f_ff[SEL_BLEND]) * 35'(q_t_ff) + 35'(HALF_Q16);

      for (int i = 0; i < 3; i++) begin
         cl_sum[i] = (CLS'(su_ff[i]) + CLS'(tv_ff[i]) + CLS'($signed({1'b0, HALF_Q16})))
                     >>> 16;
         cl_val[i] = cl_sum[i] + CLS'($signed(job_ff.v0[i]));
         if (cl_val[i][CLS-1:COORD_BITS-1] == '0
             || cl_val[i][CLS-1:COORD_BITS-1] == '1) begin
            cl_sat[i] = cl_val[i][COORD_BITS-1:0];
         end else if (cl_val[i][CLS-1]) begin
            cl_sat[i] = {1'b1, {(COORD_BITS-1){1'b0}}};
         end else begin
            cl_sat[i] = {1'b0, {(COORD_BITS-1){1'b1}}};
         end
         e_c[i] = DIFF_BITS'($signed(job_ff.pt[i])) - DIFF_BITS'($signed(cl_ff[i]));
      end
      sq_sum = SQW'(sq_ff[0]) + SQW'(sq_ff[1]) + SQW'(sq_ff[2]);

      trial = res_ff + bit_ff;
      if (sv_ff >= trial) begin
         sv_next = sv_ff - trial;
         res_next = (res_ff >> 1) + bit_ff;
      end else begin
         sv_next = sv_ff;
         res_next = res_ff >> 1;
      end
      w0 = {1'b0, ONE_Q16} - {1'b0, s_ff} - {1'b0, t_ff};
      pop = (state_ff == ST_IDLE) && !q_empty;
   end

   ptcp_frac u_frac (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num(div_num),
      .den(div_den),
      .done(div_done),
      .quot(div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         div_run_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         div_sel_ff <= SEL_EV;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  job_ff <= pop_data;
                  div_sel_ff <= SEL_EV;
                  div_run_ff <= 1'b0;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_start) begin
                  div_run_ff <= 1'b1;
               end
               if (div_done) begin
                  f_ff[div_sel_ff] <= div_quot;
                  div_run_ff <= 1'b0;
                  if (div_sel_ff == SEL_OU) begin
                     state_ff <= ST_SEL;
                  end else if (div_sel_ff == SEL_BLEND) begin
                     state_ff <= ST_BLEND;
                  end else begin
                     div_sel_ff <= div_sel_ff + 1'b1;
                  end
               end
            end
            ST_SEL: begin
               if (go_ge && gv_ge) begin
                  s_ff <= '0;
                  t_ff <= ev_t;
                  state_ff <= ST_CL1;
               end else if (!go_ge && !gv_gt && gu_le) begin
                  s_ff <= ONE_Q16 - euv_t;
                  t_ff <= euv_t;
                  state_ff <= ST_CL1;
               end else begin
                  state_ff <= ST_G0S;
                  if (go_ge || (gv_gt && gu_le)) begin
                     p_s_ff <= '0;
                     p_t_ff <= f_ff[SEL_OV];
                     q_s_ff <= f_ff[SEL_VU];
                     q_t_ff <= w3c;
                     fpos_ff <= !fac_a[WEIGHT_BITS+1] && (fac_a != '0);
                     fneg_ff <= fac_a[WEIGHT_BITS+1];
                     a0_s_ff <= '0;
                     a0_t_ff <= ev_t;
                     a1_s_ff <= ONE_Q16 - euv_t;
                     a1_t_ff <= euv_t;
                  end else if (!gv_gt) begin
                     p_s_ff <= f_ff[SEL_OU];
                     p_t_ff <= '0;
                     q_s_ff <= f_ff[SEL_VU];
                     q_t_ff <= w3c;
                     fpos_ff <= (w3c != '0);
                     fneg_ff <= 1'b0;
                     a0_s_ff <= f_ff[SEL_OU];
                     a0_t_ff <= '0;
                     a1_s_ff <= ONE_Q16 - euv_t;
                     a1_t_ff <= euv_t;
                  end else begin
                     p_s_ff <= f_ff[SEL_OU];
                     p_t_ff <= '0;
                     q_s_ff <= '0;
                     q_t_ff <= f_ff[SEL_OV];
                     fpos_ff <= (f_ff[SEL_OV] != '0);
                     fneg_ff <= 1'b0;
                     a0_s_ff <= f_ff[SEL_OU];
                     a0_t_ff <= '0;
                     a1_s_ff <= '0;
                     a1_t_ff <= ev_t;
                  end
               end
            end
            ST_G0S: begin
               g_acc_ff <= lv_sh + prod;
               state_ff <= ST_G0T;
            end
            ST_G0T: begin
               g0_ff <= g_acc_ff + prod;
               state_ff <= ST_G1S;
            end
            ST_G1S: begin
               g_acc_ff <= lv_sh + prod;
               state_ff <= ST_G1T;
            end
            ST_G1T: begin
               g1_ff <= g_acc_ff + prod;
               state_ff <= ST_DEC;
            end
            ST_DEC: begin
               if (alt0_take) begin
                  s_ff <= a0_s_ff;
                  t_ff <= a0_t_ff;
                  state_ff <= ST_CL1;
               end else if (alt1_take) begin
                  s_ff <= a1_s_ff;
                  t_ff <= a1_t_ff;
                  state_ff <= ST_CL1;
               end else begin
                  div_sel_ff <= SEL_BLEND;
                  div_run_ff <= 1'b0;
                  state_ff <= ST_DIV;
               end
            end
            ST_BLEND: begin
               s_ff <= bs[32:16];
               t_ff <= bt[32:16];
               state_ff <= ST_CL1;
            end
            ST_CL1: begin
               for (int i = 0; i < 3; i++) begin
                  su_ff[i] <= CLM'($signed({1'b0, s_ff}) * $signed(job_ff.eu[i]));
                  tv_ff[i] <= CLM'($signed({1'b0, t_ff}) * $signed(job_ff.ev[i]));
               end
               state_ff <= ST_CL2;
            end
            ST_CL2: begin
               cl_ff <= cl_sat;
               state_ff <= ST_SQ1;
            end
            ST_SQ1: begin
               for (int i = 0; i < 3; i++) begin
                  sq_ff[i] <= e_c[i] * e_c[i];
               end
               state_ff <= ST_SQ2;
            end
            ST_SQ2: begin
               sqd_ff <= sq_sum[SQD_BITS] ? '1 : sq_sum[SQD_BITS-1:0];
               sv_ff <= sq_sum[SQD_BITS] ? '1 : sq_sum[SQD_BITS-1:0];
               res_ff <= '0;
               bit_ff <= SQD_BITS'(1) << (SQD_BITS - 2);
               scnt_ff <= '0;
               state_ff <= ST_SQRT;
            end
            ST_SQRT: begin
               sv_ff <= sv_next;
               res_ff <= res_next;
               bit_ff <= bit_ff >> 2;
               scnt_ff <= scnt_ff + 1'b1;
               if (scnt_ff == 5'(SQRT_STEPS - 1)) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff.weight0 <= w0[WEIGHT_BITS] ? '0 : w0[WEIGHT_BITS-1:0];
                  rsp_data_ff.weight1 <= s_ff;
                  rsp_data_ff.weight2 <= t_ff;
                  rsp_data_ff.closest_x <= cl_ff[0];
                  rsp_data_ff.closest_y <= cl_ff[1];
                  rsp_data_ff.closest_z <= cl_ff[2];
                  rsp_data_ff.squared_distance <= sqd_ff;
                  rsp_data_ff.distance <= res_next[DIST_BITS-1:0];
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;
endmodule
`default_nettype wire

// ===== rtl/point_triangle_closest_point.sv =====
// Top level of the point-to-triangle closest point block.
// Depends on ptcp_pkg, ptcp_front, ptcp_queue and ptcp_back.
//
//   channel   ports                      direction  transfer
//   request   start, busy, req_data      in         start high while busy low
//   result    rsp_valid, rsp_data        out        one cycle with rsp_valid high
//
// The front end takes one request a cycle until its stages and queue hold QUEUE_DEPTH
// jobs, and queues each job from its dot-product registers. The back end takes one job at
// a time, with the shared 17-step ratio unit (five or six ratios) and 26-step square root.
// Reset is synchronous and empties the queue; results cannot be held off.
`default_nettype none
module point_triangle_closest_point #(
   parameter int QUEUE_DEPTH = ptcp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire ptcp_pkg::req_type  req_data,
   output logic                    rsp_valid,
   output ptcp_pkg::rsp_type       rsp_data
);
   import ptcp_pkg::*;

   logic push, pop, q_empty;
   job_type push_data, pop_data;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

   ptcp_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req_data(req_data),
      .q_count(q_count),
      .busy(busy),
      .push(push),
      .push_data(push_data)
   );

   ptcp_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_data(push_data),
      .pop(pop),
      .pop_data(pop_data),
      .empty(q_empty),
      .count(q_count)
   );

   ptcp_back u_back (
      .clock(clock),
      .reset(reset),
      .q_empty(q_empty),
      .pop_data(pop_data),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("back-to-back results");
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= ($bits(q_count))'(QUEUE_DEPTH)) else $error("queue overfilled");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_empty) else $error("pop from empty queue");
   a_weight_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.weight0 == '0) ||
      (({1'b0, rsp_data.weight0} + {1'b0, rsp_data.weight1} + {1'b0, rsp_data.weight2})
       == {1'b0, ONE_Q16})) else $error("weights do not sum to one");
`endif
endmodule
`default_nettype wire

// ===== bench/tb_point_triangle_closest_point.sv =====
// Self-checking testbench for point_triangle_closest_point: directed and random queries,
// each checked against a bit-exact fixed-point closest-point predictor held in a scoreboard.
// Depends on ptcp_pkg and the block's RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb_point_triangle_closest_point;
   import ptcp_pkg::*;

   typedef logic signed [127:0] acc_type;
   typedef struct {
      longint s;
      longint t;
   } edge_wt_type;

   class closest_point_board;
      rsp_type awaited[$];
      int errors;
      int checked;

      function automatic int sgn(acc_type a);
         return (a < 0) ? -1 : ((a == 0) ? 0 : 1);
      endfunction

      function automatic longint ratio_q16(acc_type n, acc_type d);
         longint q;
         q = 0;
         if (d < 0) begin
            n = -n;
            d = -d;
         end
         if (d == 0 || n <= 0) return 0;
         if (n >= d) return 65536;
         for (int i = 0; i < 17; i++) begin
            n = n <<< 1;
            q = q << 1;
            if (n >= d) begin
               n = n - d;
               q = q | 1;
            end
         end
         return (q + 1) >> 1;
      endfunction

      function automatic edge_wt_type along_v(acc_type vv, acc_type lv);
         edge_wt_type r;
         r.s = 0;
         if (lv >= 0) r.t = 0;
         else if (vv + lv <= 0) r.t = 65536;
         else r.t = ratio_q16(-lv, vv);
         return r;
      endfunction

      function automatic edge_wt_type along_uv(acc_type uv, acc_type vv, acc_type lv,
                                               acc_type gu, acc_type gv);
         edge_wt_type r;
         acc_type k0, k1;
         k0 = uv + lv - gu;
         if (k0 >= 0) begin
            r.t = 0;
         end else begin
            k1 = vv + lv - gv;
            if (k1 <= 0) r.t = 65536;
            else r.t = ratio_q16(k0, k0 - k1);
         end
         r.s = 65536 - r.t;
         return r;
      endfunction

      function automatic acc_type slope_at(edge_wt_type p, acc_type uv, acc_type vv,
                                           acc_type lv);
         acc_type ps, pt;
         ps = p.s;
         pt = p.t;
         return uv * ps + vv * pt + lv * acc_type'(65536);
      endfunction

      function automatic edge_wt_type weights_for(acc_type uu, acc_type uv, acc_type vv,
                                                  acc_type lu, acc_type lv);
         acc_type go, gu, gv, g0, g1, m0;
         edge_wt_type ev, euv, p, q, alt0, alt1, r;
         longint factor, z;
         int fs;
         go = lu;
         gu = lu + uu;
         gv = lu + uv;
         ev = along_v(vv, lv);
         euv = along_uv(uv, vv, lv, gu, gv);
         if (go >= 0 && gv >= 0) return ev;
         if (go < 0 && gv <= 0 && gu <= 0) return euv;
         if (go >= 0 || (gv > 0 && gu <= 0)) begin
            p.s = 0;
            p.t = ratio_q16(go, go - gv);
            q.s = ratio_q16(gv, gv - gu);
            q.t = 65536 - q.s;
            factor = q.t - p.t;
            alt0 = ev;
            alt1 = euv;
         end else if (gv <= 0) begin
            p.s = ratio_q16(go, go - gu);
            p.t = 0;
            q.s = ratio_q16(gv, gv - gu);
            q.t = 65536 - q.s;
            factor = q.t;
            alt0 = p;
            alt1 = euv;
         end else begin
            p.s = ratio_q16(go, go - gu);
            p.t = 0;
            q.s = 0;
            q.t = ratio_q16(go, go - gv);
            factor = q.t;
            alt0 = p;
            alt1 = ev;
         end
         fs = (factor > 0) ? 1 : ((factor < 0) ? -1 : 0);
         g0 = slope_at(p, uv, vv, lv);
         g1 = slope_at(q, uv, vv, lv);
         if (fs * sgn(g0) >= 0) return alt0;
         if (fs * sgn(g1) <= 0) return alt1;
         m0 = (g0 < 0) ? -g0 : g0;
         z = ratio_q16(m0, m0 + ((g1 < 0) ? -g1 : g1));
         r.s = ((65536 - z) * p.s + z * q.s + 32768) >> 16;
         r.t = ((65536 - z) * p.t + z * q.t + 32768) >> 16;
         return r;
      endfunction

      function automatic longint unsigned int_sqrt(longint unsigned v);
         longint unsigned res, b;
         res = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= res + b) begin
               v = v - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b = b >> 2;
         end
         return res;
      endfunction

      function void note(req_type rq);
         longint pt[3], v0[3], eu[3], ev[3], dv[3], cl[3];
         acc_type uu, uv, vv, du, dvv;
         edge_wt_type w;
         longint c, d, sd, w0;
         longint cmax, cmin;
         longint unsigned root;
         rsp_type e;
         cmax = (64'sd1 <<< (COORD_BITS - 1)) - 1;
         cmin = -cmax - 1;
         pt = '{longint'(rq.query_x), longint'(rq.query_y), longint'(rq.query_z)};
         v0 = '{longint'(rq.vertex0_x), longint'(rq.vertex0_y), longint'(rq.vertex0_z)};
         eu = '{longint'(rq.vertex1_x), longint'(rq.vertex1_y), longint'(rq.vertex1_z)};
         ev = '{longint'(rq.vertex2_x), longint'(rq.vertex2_y), longint'(rq.vertex2_z)};
         uu = 0;
         uv = 0;
         vv = 0;
         du = 0;
         dvv = 0;
         for (int i = 0; i < 3; i++) begin
            eu[i] = eu[i] - v0[i];
            ev[i] = ev[i] - v0[i];
            dv[i] = pt[i] - v0[i];
            uu = uu + acc_type'(eu[i] * eu[i]);
            uv = uv + acc_type'(eu[i] * ev[i]);
            vv = vv + acc_type'(ev[i] * ev[i]);
            du = du + acc_type'(dv[i] * eu[i]);
            dvv = dvv + acc_type'(dv[i] * ev[i]);
         end
         w = weights_for(uu, uv, vv, -du, -dvv);
         sd = 0;
         for (int i = 0; i < 3; i++) begin
            c = v0[i] + ((w.s * eu[i] + w.t * ev[i] + 32768) >>> 16);
            if (c > cmax) c = cmax;
            if (c < cmin) c = cmin;
            cl[i] = c;
            d = pt[i] - c;
            sd = sd + d * d;
         end
         if (sd > (64'sd1 <<< 52) - 1) sd = (64'sd1 <<< 52) - 1;
         w0 = 65536 - w.s - w.t;
         if (w0 < 0) w0 = 0;
         root = int_sqrt(longint'(sd));
         e.weight0 = w0[WEIGHT_BITS-1:0];
         e.weight1 = w.s[WEIGHT_BITS-1:0];
         e.weight2 = w.t[WEIGHT_BITS-1:0];
         e.closest_x = cl[0][COORD_BITS-1:0];
         e.closest_y = cl[1][COORD_BITS-1:0];
         e.closest_z = cl[2][COORD_BITS-1:0];
         e.squared_distance = sd[SQD_BITS-1:0];
         e.distance = root[DIST_BITS-1:0];
         awaited.push_back(e);
      endfunction

      function void field(string name, longint e, longint a);
         if (e != a) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
         end
      endfunction

      function void check(rsp_type a);
         rsp_type e;
         if (awaited.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %h", $time, a);
            return;
         end
         e = awaited.pop_front();
         checked++;
         field("weight0", e.weight0, a.weight0);
         field("weight1", e.weight1, a.weight1);
         field("weight2", e.weight2, a.weight2);
         field("closest_x", e.closest_x, a.closest_x);
         field("closest_y", e.closest_y, a.closest_y);
         field("closest_z", e.closest_z, a.closest_z);
         field("squared_distance", e.squared_distance, a.squared_distance);
         field("distance", e.distance, a.distance);
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   localparam int CYCLE_LIMIT = 1500000;
   localparam int RANDOM_ITEMS = 1750;
   localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   int cycles = 0;
   int sent = 0;
   closest_point_board board = new();

   point_triangle_closest_point DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[point_triangle_closest_point] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check(rsp_data);
   end

   function automatic req_type make_query(int qx, int qy, int qz, int ax, int ay, int az,
                                          int bx, int by, int bz, int cx, int cy, int cz);
      req_type r;
      r.query_x = qx[COORD_BITS-1:0];
      r.query_y = qy[COORD_BITS-1:0];
      r.query_z = qz[COORD_BITS-1:0];
      r.vertex0_x = ax[COORD_BITS-1:0];
      r.vertex0_y = ay[COORD_BITS-1:0];
      r.vertex0_z = az[COORD_BITS-1:0];
      r.vertex1_x = bx[COORD_BITS-1:0];
      r.vertex1_y = by[COORD_BITS-1:0];
      r.vertex1_z = bz[COORD_BITS-1:0];
      r.vertex2_x = cx[COORD_BITS-1:0];
      r.vertex2_y = cy[COORD_BITS-1:0];
      r.vertex2_z = cz[COORD_BITS-1:0];
      return r;
   endfunction

   function automatic int near(int centre, int spread);
      return centre + $urandom_range(2 * spread) - spread;
   endfunction

   function automatic req_type random_query();
      req_type r;
      int cx, cy, cz, sp, qs;
      int pick;
      pick = $urandom_range(99);
      if (pick < 15) begin
         r = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
              $urandom(), $urandom(), $urandom()};
         return r;
      end
      sp = (pick < 25) ? 4 : ((pick < 70) ? 4096 : 200000);
      qs = 2 * sp;
      cx = near(0, 1 << 21);
      cy = near(0, 1 << 21);
      cz = near(0, 1 << 21);
      return make_query(near(cx, qs), near(cy, qs), near(cz, qs),
                        near(cx, sp), near(cy, sp), near(cz, sp),
                        near(cx, sp), near(cy, sp), near(cz, sp),
                        near(cx, sp), near(cy, sp), near(cz, sp));
   endfunction

   task automatic send(req_type r, bit may_idle);
      if (may_idle && $urandom_range(99) < 12) begin
         start <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_data <= r;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note(r);
      sent++;
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (board.pending() > 0) @(posedge clock);
   endtask

   initial begin
      req_type directed[$];
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed.push_back(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_query(300, 500, -70, 100, 100, 100, 100, 100, 100, 100, 100, 100));
      directed.push_back(make_query(700, -900, 40, 0, 0, 0, 2560, 0, 0, 5120, 0, 0));
      directed.push_back(make_query(640, 640, 512, 0, 0, 0, 2560, 0, 0, 0, 2560, 0));
      directed.push_back(make_query(-900, -700, 300, 0, 0, 0, 2560, 0, 0, 0, 2560, 0));
      directed.push_back(make_query(4000, -300, -20, 0, 0, 0, 2560, 0, 0, 0, 2560, 0));
      directed.push_back(make_query(-300, 4000, 99, 0, 0, 0, 2560, 0, 0, 0, 2560, 0));
      directed.push_back(make_query(1200, -800, 0, 0, 0, 0, 2560, 0, 0, 0, 2560, 0));
      directed.push_back(make_query(-800, 1200, 0, 0, 0, 0, 2560, 0, 0, 0, 2560, 0));
      directed.push_back(make_query(2000, 2000, -256, 0, 0, 0, 2560, 0, 0, 0, 2560, 0));
      directed.push_back(make_query(2560, 0, 0, 0, 0, 0, 2560, 0, 0, 0, 2560, 0));
      directed.push_back(make_query(853, 853, 0, 0, 0, 0, 2560, 0, 0, 0, 2560, 0));
      directed.push_back(make_query(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMIN, CMAX,
                                    CMIN, CMAX, CMAX));
      directed.push_back(make_query(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN,
                                    CMIN, CMIN, CMIN));
      directed.push_back(make_query(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN,
                                    CMIN, CMIN, CMAX));
      directed.push_back(make_query(-1, -1, -1, CMIN, 0, 0, CMAX, 0, 0, 0, CMAX, 0));
      directed.push_back(make_query(1, 2, 3, 0, 0, 0, 1, 0, 0, 0, 1, 0));
      directed.push_back(make_query(5, 5, 5, 7, 7, 7, 7, 7, 7, 9, 9, 9));
      foreach (directed[i]) send(directed[i], 1'b0);
      drain();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         send(random_query(), !(i >= 600 && i < 900));
         if (i == 1200) drain();
      end
      drain();
      repeat (200) @(posedge clock);

      $display("Sent %0d queries (directed corner, edge, vertex and degenerate cases, then",
               sent);
      $display("random local and full-range triangles); %0d results checked.", board.checked);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("[point_triangle_closest_point] OK");
      end else begin
         $display("[point_triangle_closest_point] ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/ptcp_pkg.sv
rtl/ptcp_front.sv
rtl/ptcp_queue.sv
rtl/ptcp_frac.sv
rtl/ptcp_back.sv
rtl/point_triangle_closest_point.sv
bench/tb_point_triangle_closest_point.sv
